@@ src/stoi_pkg.sv @@
// shared types and constants for the string to integer converter
`timescale 1ns / 1ps
`default_nettype none

package stoi_pkg;

    localparam int CHAR_W        = 8;
    localparam int VALUE_W       = 32;
    localparam int LEN_W         = 5;
    localparam int DIGIT_W       = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int SYMS_PER_WORD = CFG_DATA_W / CHAR_W;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [LEN_W-1:0] MIN_BASE_LEN = 5'd2;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_DONE
    } t_phase;

    // one classified character as it crosses from front to back
    typedef struct packed {
        logic               is_blank;
        logic               is_plus;
        logic               is_minus;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
        logic [LEN_W-1:0]   base_len;
        logic               base_valid;
        logic               is_final;
    } t_class;

endpackage

`default_nettype wire

@@ src/stoi_ifs.sv @@
// valid/ready channel interfaces for characters in and results out
`timescale 1ns / 1ps
`default_nettype none

interface stoi_in_if import stoi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              is_final;

    modport source (output valid, output character, output is_final, input ready);
    modport sink   (input valid, input character, input is_final, output ready);
endinterface

interface stoi_out_if import stoi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      base_valid;

    modport source (output valid, output value, output base_valid, input ready);
    modport sink   (input valid, input value, input base_valid, output ready);
endinterface

`default_nettype wire

@@ src/stoi_front.sv @@
// front end: symbol table registers, base check and character classification
`timescale 1ns / 1ps
`default_nettype none

module stoi_front import stoi_pkg::*; #(
    parameter int MAX_BASE = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    stoi_in_if.sink               i_char_ch,
    input  wire                   i_full,
    output logic                  o_push,
    output t_class                o_word
);

    logic [MAX_BASE-1:0][CHAR_W-1:0] r_sym;
    logic [LEN_W-1:0]                r_base_len;
    logic                            bad_sym;
    logic                            base_valid;
    logic                            hit;
    logic [DIGIT_W-1:0]              digit;
    logic [CHAR_W-1:0]               ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym      <= '0;
            r_base_len <= '0;
        end else if (i_cfg_we) begin
            for (int k = 0; k < MAX_BASE; k++) begin
                if ((k < SYMS_PER_WORD && i_cfg_idx == CFG_SYMBOLS_LOW) ||
                    (k >= SYMS_PER_WORD && i_cfg_idx == CFG_SYMBOLS_HIGH)) begin
                    r_sym[k] <= i_cfg_data[(k % SYMS_PER_WORD)*CHAR_W +: CHAR_W];
                end
            end
            if (i_cfg_idx == CFG_BASE_LENGTH) begin
                r_base_len <= i_cfg_data[LEN_W-1:0];
            end
        end
    end

    // symbols in use must be above space, at most DEL, not a sign, and pairwise distinct
    always_comb begin
        bad_sym = 1'b0;
        for (int k = 0; k < MAX_BASE; k++) begin
            if (LEN_W'(k) < r_base_len) begin
                if (r_sym[k] <= CH_SPACE || r_sym[k] > CH_DEL ||
                    r_sym[k] == CH_PLUS || r_sym[k] == CH_MINUS) begin
                    bad_sym = 1'b1;
                end
                for (int j = k + 1; j < MAX_BASE; j++) begin
                    if (LEN_W'(j) < r_base_len && r_sym[j] == r_sym[k]) begin
                        bad_sym = 1'b1;
                    end
                end
            end
        end
        base_valid = !bad_sym && r_base_len >= MIN_BASE_LEN &&
                     r_base_len <= LEN_W'(MAX_BASE);
    end

    assign ch = i_char_ch.character;

    // parallel compare against the symbol table
    always_comb begin
        hit   = 1'b0;
        digit = '0;
        for (int k = 0; k < MAX_BASE; k++) begin
            if (!hit && LEN_W'(k) < r_base_len && r_sym[k] == ch) begin
                hit   = 1'b1;
                digit = DIGIT_W'(k);
            end
        end
    end

    assign i_char_ch.ready = !i_full;
    assign o_push          = i_char_ch.valid && !i_full;

    always_comb begin
        o_word.is_blank   = (ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE;
        o_word.is_plus    = ch == CH_PLUS;
        o_word.is_minus   = ch == CH_MINUS;
        o_word.is_digit   = hit && base_valid;
        o_word.digit      = digit;
        o_word.base_len   = r_base_len;
        o_word.base_valid = base_valid;
        o_word.is_final   = i_char_ch.is_final;
    end

endmodule

`default_nettype wire

@@ src/stoi_fifo.sv @@
// short queue of classified words between front and back
`timescale 1ns / 1ps
`default_nettype none

module stoi_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire  [W-1:0] i_data,
    output logic         o_full,
    input  wire          i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ src/stoi_back.sv @@
// back end: parse state machine, digit accumulator and result register
`timescale 1ns / 1ps
`default_nettype none

module stoi_back import stoi_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire t_class i_word,
    output logic        o_pop,
    stoi_out_if.source  o_result_ch
);

    t_phase                    r_phase, n_phase;
    logic                      r_neg,   n_neg;
    logic [VALUE_W-1:0]        r_acc,   n_acc;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_base_valid;
    logic [VALUE_W+LEN_W-1:0]  prod;
    logic [VALUE_W-1:0]        step_acc;
    logic [VALUE_W-1:0]        result;

    // a final word needs room in the result register
    assign o_pop = i_valid && (!i_word.is_final || !r_out_valid || o_result_ch.ready);

    assign prod = r_acc * i_word.base_len;

    always_comb begin
        n_phase  = r_phase;
        n_neg    = r_neg;
        step_acc = r_acc;
        if (n_phase == PH_SPACE && !i_word.is_blank) begin
            n_phase = PH_SIGN;
        end
        if (n_phase == PH_SIGN) begin
            if (i_word.is_minus) begin
                n_neg = !n_neg;
            end else if (!i_word.is_plus) begin
                n_phase = PH_DIGIT;
            end
        end
        if (n_phase == PH_DIGIT) begin
            if (i_word.is_digit) begin
                step_acc = prod[VALUE_W-1:0] + VALUE_W'(i_word.digit);
            end else begin
                n_phase = PH_DONE;
            end
        end
        result = '0;
        if (i_word.base_valid) begin
            result = n_neg ? ('0 - step_acc) : step_acc;
        end
        n_acc = step_acc;
        if (i_word.is_final) begin
            n_phase = PH_SPACE;
            n_neg   = 1'b0;
            n_acc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_word.is_final) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_word.is_final) begin
            r_value      <= result;
            r_base_valid <= i_word.base_valid;
        end
    end

    assign o_result_ch.valid      = r_out_valid;
    assign o_result_ch.value      = r_value;
    assign o_result_ch.base_valid = r_base_valid;

endmodule

`default_nettype wire

@@ src/string_to_int_any_base_unit.sv @@
// top level of the string to integer converter with a configurable digit set
//
// Takes one character word per cycle while the queue has room, and presents one result
// word on each word flagged final, on the output the cycle after the back takes that
// word from the queue. The front classifies each character against the
// symbol table combinationally (parallel compares, plus the pairwise base check
// on the configuration registers); the back runs the parse state machine with
// one 32x5 multiply-add per cycle while not stalled on a result; a two-entry queue
// between them lets the input keep flowing while a result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module string_to_int_any_base_unit import stoi_pkg::*; #(
    parameter int MAX_BASE = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire                  i_cfg_we,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    stoi_in_if.sink              i_char_ch,
    stoi_out_if.source           o_result_ch
);

    t_class                     enq_word;
    t_class                     deq_word;
    logic [$bits(t_class)-1:0]  deq_bits;
    logic                       push;
    logic                       full;
    logic                       deq_valid;
    logic                       pop;

    stoi_front #(
        .MAX_BASE (MAX_BASE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_char_ch  (i_char_ch),
        .i_full     (full),
        .o_push     (push),
        .o_word     (enq_word)
    );

    stoi_fifo #(
        .W     ($bits(t_class)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (enq_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (deq_valid),
        .o_data  (deq_bits)
    );

    assign deq_word = t_class'(deq_bits);

    stoi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (deq_valid),
        .i_word      (deq_word),
        .o_pop       (pop),
        .o_result_ch (o_result_ch)
    );

endmodule

`default_nettype wire

@@ src/stoi_checker.sv @@
// port-level checks on the converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module stoi_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_out_value,
    input wire        i_out_base_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_value) && $stable(i_out_base_valid))
        else $error("result word changed while stalled");

    a_bad_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_base_valid |-> i_out_value == 32'd0)
        else $error("nonzero value with an illegal base");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("converter not idle after reset");

endmodule

bind string_to_int_any_base_unit stoi_checker u_stoi_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_char_ch.ready),
    .i_out_valid      (o_result_ch.valid),
    .i_out_ready      (o_result_ch.ready),
    .i_out_value      (o_result_ch.value),
    .i_out_base_valid (o_result_ch.base_valid)
);

`default_nettype wire
